[hdl/bll_pkg.sv]
// Package for the Bresenham line pixel generator.
// Holds the shared constants, the command and register codes and the color helpers.
// No dependencies.
package bll_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int SCREEN_BITS    = 11;
  localparam int COLOR_BITS     = 16;
  localparam int CHAN_BITS      = 8;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 11'd480;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 11'd320;

  localparam logic [COLOR_BITS-1:0] RED_MASK   = 16'hF800;
  localparam logic [COLOR_BITS-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [COLOR_BITS-1:0] BLUE_MASK  = 16'h001F;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  // RGB565 to RGB888, low bits zero
  function automatic logic [CHAN_BITS-1:0] red_888(input logic [COLOR_BITS-1:0] c);
    logic [COLOR_BITS-1:0] m;
    m = (c & RED_MASK) >> 8;
    return m[CHAN_BITS-1:0];
  endfunction

  function automatic logic [CHAN_BITS-1:0] green_888(input logic [COLOR_BITS-1:0] c);
    logic [COLOR_BITS-1:0] m;
    m = (c & GREEN_MASK) >> 3;
    return m[CHAN_BITS-1:0];
  endfunction

  function automatic logic [CHAN_BITS-1:0] blue_888(input logic [COLOR_BITS-1:0] c);
    logic [COLOR_BITS-1:0] m;
    m = (c & BLUE_MASK) << 3;
    return m[CHAN_BITS-1:0];
  endfunction

endpackage

[hdl/bll_in_if.sv]
// Input channel of the line generator: valid/ready plus the command item.
// Depends on bll_pkg.
interface bll_in_if import bll_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0] color_565;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, color_565,
                  input ready);
  modport sink (input valid, cmd, x_start, y_start, x_end, y_end, color_565,
                output ready);
endinterface

[hdl/bll_out_if.sv]
// Result channel of the line generator: valid/ready plus the pixel item.
// Depends on bll_pkg.
interface bll_out_if import bll_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  valid_res;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [CHAN_BITS-1:0]  red;
  logic [CHAN_BITS-1:0]  green;
  logic [CHAN_BITS-1:0]  blue;
  logic                  visible;
  logic                  last;

  modport source (output valid, valid_res, pixel_x, pixel_y, red, green, blue, visible, last,
                  input ready);
  modport sink (input valid, valid_res, pixel_x, pixel_y, red, green, blue, visible, last,
                output ready);
endinterface

[hdl/bresenham_line_pixel_generator.sv]
// One item per cycle while the skid entry is empty; the Bresenham update and pixel checks are one register stage.
// A two-entry output buffer (result register plus skid) keeps input accepted while a result waits.
// Reset (rst_n low, synchronous): no line active, line state cleared, buffer empty,
// screen 480 x 320.
// Depends on bll_pkg, bll_in_if, bll_out_if.
module bresenham_line_pixel_generator import bll_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  bll_in_if.sink                  in_ch,
  bll_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SCREEN_BITS-1:0]  cfg_data
);

  localparam int EW   = COORD_BITS + 2;
  localparam int E2W  = COORD_BITS + 3;
  localparam int CMPW = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

  typedef struct packed {
    logic                  valid_res;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [CHAN_BITS-1:0]  red;
    logic [CHAN_BITS-1:0]  green;
    logic [CHAN_BITS-1:0]  blue;
    logic                  visible;
    logic                  last;
  } res_t;

  // screen size
  logic [SCREEN_BITS-1:0] scr_w_r, scr_h_r;

  // line state
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r, dx_r, dy_r;
  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt, dx_nxt, dy_nxt;
  logic                  sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  active_r, active_nxt;

  // output buffer
  res_t res_nxt, out_r, skid_r;
  logic out_vld_r, skid_vld_r;

  logic in_acc, out_acc;

  logic signed [E2W-1:0] e2, dx_s, dy_s, err_sub, err_add, err_sum;
  logic                  step_x, step_y, is_last;

  assign in_ch.ready = !skid_vld_r;
  assign in_acc      = in_ch.valid && !skid_vld_r;
  assign out_acc     = out_vld_r && out_ch.ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bresenham update and pixel result
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sxn_nxt    = sxn_r;
    syn_nxt    = syn_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    res_nxt    = '0;

    e2      = $signed({err_r, 1'b0});
    dx_s    = $signed(E2W'(dx_r));
    dy_s    = $signed(E2W'(dy_r));
    step_x  = (e2 > -dy_s);
    step_y  = (e2 < dx_s);
    err_sub = step_x ? dy_s : '0;
    err_add = step_y ? dx_s : '0;
    err_sum = $signed({err_r[EW-1], err_r}) - err_sub + err_add;

    if (in_ch.cmd == CMD_START) begin
      cur_x_nxt  = in_ch.x_start;
      cur_y_nxt  = in_ch.y_start;
      goal_x_nxt = in_ch.x_end;
      goal_y_nxt = in_ch.y_end;
      dx_nxt     = (in_ch.x_end >= in_ch.x_start) ? in_ch.x_end - in_ch.x_start
                                                  : in_ch.x_start - in_ch.x_end;
      dy_nxt     = (in_ch.y_end >= in_ch.y_start) ? in_ch.y_end - in_ch.y_start
                                                  : in_ch.y_start - in_ch.y_end;
      sxn_nxt    = !(in_ch.x_start < in_ch.x_end);
      syn_nxt    = !(in_ch.y_start < in_ch.y_end);
      err_sum    = $signed(E2W'(dx_nxt)) - $signed(E2W'(dy_nxt));
      err_nxt    = err_sum[EW-1:0];
      color_nxt  = in_ch.color_565;
    end else if (active_r) begin
      if (step_x) begin
        cur_x_nxt = sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      end
      if (step_y) begin
        cur_y_nxt = syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
      end
      err_nxt = err_sum[EW-1:0];
    end

    is_last = (cur_x_nxt == goal_x_nxt) && (cur_y_nxt == goal_y_nxt);

    // a step with no line in progress yields an all-zero result
    if (in_ch.cmd == CMD_START || active_r) begin
      active_nxt        = !is_last;
      res_nxt.valid_res = 1'b1;
      res_nxt.pixel_x   = cur_x_nxt;
      res_nxt.pixel_y   = cur_y_nxt;
      res_nxt.red       = red_888(color_nxt);
      res_nxt.green     = green_888(color_nxt);
      res_nxt.blue      = blue_888(color_nxt);
      res_nxt.visible   = (CMPW'(cur_x_nxt) < CMPW'(scr_w_r)) &&
                          (CMPW'(cur_y_nxt) < CMPW'(scr_h_r));
      res_nxt.last      = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (in_acc) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
    end else if (in_acc) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      sxn_r    <= sxn_nxt;
      syn_r    <= syn_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_acc) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_vld_r && !out_ch.ready) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_acc) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_vld_r && !out_ch.ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.valid_res = out_r.valid_res;
  assign out_ch.pixel_x   = out_r.pixel_x;
  assign out_ch.pixel_y   = out_r.pixel_y;
  assign out_ch.red       = out_r.red;
  assign out_ch.green     = out_r.green;
  assign out_ch.blue      = out_r.blue;
  assign out_ch.visible   = out_r.visible;
  assign out_ch.last      = out_r.last;

endmodule

[hdl/bll_chk.sv]
// Port-level checker for the line generator, attached to the top level by bind.
// Depends on bll_pkg and bresenham_line_pixel_generator.
module bll_chk import bll_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_valid_res,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic [CHAN_BITS-1:0]  out_red,
  input logic [CHAN_BITS-1:0]  out_green,
  input logic [CHAN_BITS-1:0]  out_blue,
  input logic                  out_visible,
  input logic                  out_last
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
                                $stable(out_valid_res) && $stable(out_last))
    else $error("result changed while stalled");

  // no line: every field zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_pixel_x == '0 && out_pixel_y == '0 &&
      out_red == '0 && out_green == '0 && out_blue == '0 && !out_visible && !out_last)
    else $error("idle step result not zero");

  a_flags_need_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_last || out_visible) |-> out_valid_res)
    else $error("flag set without pixel");

endmodule

bind bresenham_line_pixel_generator bll_chk #(.COORD_BITS(COORD_BITS)) u_bll_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_pixel_x   (out_ch.pixel_x),
  .out_pixel_y   (out_ch.pixel_y),
  .out_red       (out_ch.red),
  .out_green     (out_ch.green),
  .out_blue      (out_ch.blue),
  .out_visible   (out_ch.visible),
  .out_last      (out_ch.last)
);

[test/bresenham_line_pixel_generator_tb.sv]
// Testbench for bresenham_line_pixel_generator: feeds start and step items with random gaps
// and output stalls, traces every line with its own Bresenham tracer and checks each pixel.
// Depends on bll_pkg, bll_in_if, bll_out_if and the block itself.
module bresenham_line_pixel_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bll_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int COORD_MAX   = (1 << CB) - 1;
  localparam int RAND_ITEMS  = 1700;
  localparam int NUM_PHASES  = 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    cmd_t            cmd;
    logic [CB-1:0]   xs, ys, xe, ye;
    logic [COLOR_BITS-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic                 valid_res;
    logic [CB-1:0]        x;
    logic [CB-1:0]        y;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 visible;
    logic                 last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [SCREEN_BITS-1:0] cfg_data;

  bll_in_if  #(.COORD_BITS(CB)) in_ch();
  bll_out_if #(.COORD_BITS(CB)) out_ch();

  bresenham_line_pixel_generator #(.COORD_BITS(CB)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracer state: screen size, current line and color
  logic [SCREEN_BITS-1:0]  scr_w, scr_h;
  logic [CB-1:0]           cur_x = '0, cur_y = '0, goal_x = '0, goal_y = '0;
  logic [CB-1:0]           span_x = '0, span_y = '0;
  logic                    neg_x = 1'b0, neg_y = 1'b0, drawing = 1'b0;
  logic signed [CB+1:0]    err = '0;
  logic [COLOR_BITS-1:0]   line_color = '0;

  line_cmd_t cmds_pending[$];
  pixel_t    pixels_due[$];
  line_cmd_t shown_cmd;
  logic      in_fire = 1'b0, out_fire = 1'b0;
  logic      in_burst = 1'b0, out_burst = 1'b0;
  int        gap_left = 0, stall_left = 0;
  int        errors = 0;
  int        cycles = 0;
  int        queued;

  function automatic pixel_t emit_pixel();
    pixel_t p;
    p.valid_res = 1'b1;
    p.x         = cur_x;
    p.y         = cur_y;
    p.red       = {line_color[15:11], 3'b000};
    p.green     = {line_color[10:5], 2'b00};
    p.blue      = {line_color[4:0], 3'b000};
    p.visible   = (cur_x < scr_w) && (cur_y < scr_h);
    p.last      = (cur_x == goal_x) && (cur_y == goal_y);
    drawing     = !p.last;
    return p;
  endfunction

  function automatic pixel_t trace_pixel(line_cmd_t c);
    int e2;
    if (c.cmd == CMD_START) begin
      cur_x      = c.xs;
      cur_y      = c.ys;
      goal_x     = c.xe;
      goal_y     = c.ye;
      span_x     = (c.xe >= c.xs) ? c.xe - c.xs : c.xs - c.xe;
      span_y     = (c.ye >= c.ys) ? c.ye - c.ys : c.ys - c.ye;
      neg_x      = !(c.xs < c.xe);
      neg_y      = !(c.ys < c.ye);
      err        = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
      line_color = c.color;
      return emit_pixel();
    end
    // idle step: empty result, state untouched
    if (!drawing) return '0;
    e2 = 2 * int'(err);
    if (e2 > -int'(span_y)) begin
      err   = err - $signed({2'b00, span_y});
      cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (e2 < int'(span_x)) begin
      err   = err + $signed({2'b00, span_x});
      cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    return emit_pixel();
  endfunction

  // Stimulus helpers
  function automatic line_cmd_t step_item();
    line_cmd_t c;
    c.cmd   = CMD_STEP;
    c.xs    = CB'($urandom);
    c.ys    = CB'($urandom);
    c.xe    = CB'($urandom);
    c.ye    = CB'($urandom);
    c.color = COLOR_BITS'($urandom);
    return c;
  endfunction

  task automatic push_line(int xs, int ys, int xe, int ye, logic [COLOR_BITS-1:0] color,
                           int steps);
    line_cmd_t c;
    c.cmd   = CMD_START;
    c.xs    = CB'(xs);
    c.ys    = CB'(ys);
    c.xe    = CB'(xe);
    c.ye    = CB'(ye);
    c.color = color;
    cmds_pending.push_back(c);
    repeat (steps) cmds_pending.push_back(step_item());
    queued += steps + 1;
  endtask

  // Coordinates biased toward the edges and the usual screen area
  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) == 0) ? 0 : COORD_MAX;
      1, 2:    return $urandom_range(0, 511);
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(0, 40)) - 20;
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  task automatic push_random_line();
    int xs, ys, xe, ye, len, steps, pick;
    xs = rand_coord();
    ys = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      xe = $urandom_range(0, COORD_MAX);
      ye = $urandom_range(0, COORD_MAX);
    end else begin
      xe = near(xs);
      ye = near(ys);
    end
    len  = (xe > xs) ? xe - xs : xs - xe;
    len  = ((ye > ys) ? ye - ys : ys - ye) > len ? ((ye > ys) ? ye - ys : ys - ye) : len;
    pick = $urandom_range(0, 19);
    if (pick < 14) steps = len;                                   // run to the endpoint
    else if (pick < 17) steps = len + $urandom_range(1, 3);       // steps past the end
    else steps = $urandom_range(0, len);                          // abandoned by a restart
    if (steps > 60) steps = $urandom_range(0, 60);
    push_line(xs, ys, xe, ye, COLOR_BITS'($urandom), steps);
  endtask

  task automatic push_random(int count);
    line_cmd_t c;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        c     = step_item();
        c.cmd = cmd_t'($urandom_range(0, 1));
        cmds_pending.push_back(c);
        queued++;
      end else begin
        push_random_line();
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (cmds_pending.size() != 0 || in_ch.valid || pixels_due.size() != 0);
  endtask

  task automatic set_screen(logic [SCREEN_BITS-1:0] w, logic [SCREEN_BITS-1:0] h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Input side: acceptance and prediction at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) pixels_due.push_back(trace_pixel(shown_cmd));
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (cmds_pending.size() > 0) begin
        shown_cmd = cmds_pending.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= shown_cmd.cmd;
        in_ch.x_start   <= shown_cmd.xs;
        in_ch.y_start   <= shown_cmd.ys;
        in_ch.x_end     <= shown_cmd.xe;
        in_ch.y_end     <= shown_cmd.ye;
        in_ch.color_565 <= shown_cmd.color;
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        gap_left = in_burst ? 0 : $urandom_range(0, 12);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side
  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel item x=%0d y=%0d", $time, out_ch.pixel_x,
                 out_ch.pixel_y);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        check_field("valid_res", 16'(want.valid_res), 16'(out_ch.valid_res));
        check_field("pixel_x", 16'(want.x), 16'(out_ch.pixel_x));
        check_field("pixel_y", 16'(want.y), 16'(out_ch.pixel_y));
        check_field("red", 16'(want.red), 16'(out_ch.red));
        check_field("green", 16'(want.green), 16'(out_ch.green));
        check_field("blue", 16'(want.blue), 16'(out_ch.blue));
        check_field("visible", 16'(want.visible), 16'(out_ch.visible));
        check_field("last", 16'(want.last), 16'(out_ch.last));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
        stall_left = out_burst ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bresenham_line_pixel_generator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SCREEN_WIDTH;
    cfg_data        = '0;
    scr_w           = SCREEN_W_RST;
    scr_h           = SCREEN_H_RST;

    // Directed: idle step, single point, edge lines, restarts, screen boundary
    cmds_pending.push_back(step_item());
    push_line(0, 0, 0, 0, 16'hFFFF, 1);
    push_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 3, 16'h0000, 4);
    push_line(0, COORD_MAX, 3, COORD_MAX - 1, RED_MASK, 3);
    push_line(COORD_MAX, 0, COORD_MAX - 2, 3, GREEN_MASK, 1);
    push_line(479, 319, 480, 320, BLUE_MASK, 1);
    push_line(0, 0, COORD_MAX, COORD_MAX, 16'hAAAA, 2);
    push_line(5, 5, 5, 5, 16'h5555, 1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;  // reset screen size
        1: set_screen(11'd2047, 11'd2047);
        2: set_screen(11'd0, 11'd0);
        3: set_screen(11'd1, 11'd2047);
        4: set_screen(11'd2047, 11'd1);
        default: set_screen(SCREEN_BITS'($urandom_range(1, 2047)),
                            SCREEN_BITS'($urandom_range(1, 2047)));
      endcase
      // the sender holds off between the halves until every pixel is back
      push_random(RAND_ITEMS / (2 * NUM_PHASES));
      wait_idle();
      push_random(RAND_ITEMS / (2 * NUM_PHASES));
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("bresenham_line_pixel_generator_tb: PASS");
    end else begin
      $display("bresenham_line_pixel_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
